// File: src/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants for the RESP stream parser: event codes,
// protocol characters and field widths.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam int BYTE_W   = 8;
    localparam int EVENT_W  = 3;
    localparam int NUMBER_W = 32;

    typedef enum logic [EVENT_W-1:0] {
        EV_CONSUMED    = 3'd0,
        EV_ARRAY_START = 3'd1,
        EV_NULL_ARRAY  = 3'd2,
        EV_BULK_START  = 3'd3,
        EV_PAYLOAD     = 3'd4,
        EV_BULK_END    = 3'd5,
        EV_ERROR       = 3'd6
    } t_event;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

endpackage

// File: src/rsp_if.sv
// ----------------------------------------------------------------------------
// rsp_if
// Valid/ready channels of the RESP stream parser: the byte request channel
// and the parse result channel.
// ----------------------------------------------------------------------------
interface rsp_byte_if;
    logic                       valid;
    logic                       ready;
    logic [rsp_pkg::BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rsp_res_if;
    logic                         valid;
    logic                         ready;
    logic [rsp_pkg::EVENT_W-1:0]  event_res;
    logic [rsp_pkg::NUMBER_W-1:0] number;
    logic [rsp_pkg::BYTE_W-1:0]   payload;
    logic                         message_done;

    modport source (output valid, output event_res, output number, output payload,
                    output message_done, input ready);
    modport sink   (input valid, input event_res, input number, input payload,
                    input message_done, output ready);
endinterface

// File: src/resp_stream_parser.sv
// ----------------------------------------------------------------------------
// resp_stream_parser
// Byte-serial RESP parser: one result request per input byte request.
// ----------------------------------------------------------------------------
// Result: o_res is registered from each accepted byte; the decimal
//   accumulate (x10 + digit, overflow test) feeding the state sets the path.
// Throughput: one byte per cycle; the result register refills as it drains,
//   so i_byte.ready drops only while a result waits and o_res.ready is low.
// Reset (synchronous, active low): parser waits for a type byte, counters
//   cleared, result register empty. No clearing pass.
// ----------------------------------------------------------------------------
module resp_stream_parser #(
    parameter int LENGTH_BITS = rsp_pkg::LENGTH_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rsp_byte_if.sink        i_byte,
    rsp_res_if.source       o_res
);
    import rsp_pkg::*;

    localparam int L = LENGTH_BITS;

    // parser phases
    typedef enum logic [2:0] {
        PH_TYPE,            // expecting '$' or '*'
        PH_NUM_FIRST,       // first char of the number ('-' allowed)
        PH_NUM_AFTER_MINUS, // digit required after '-'
        PH_NUM_DIGITS,      // more digits or CR
        PH_NUM_LF,          // LF closing the header
        PH_BODY,            // payload bytes
        PH_BODY_CR,         // CR after payload
        PH_BODY_LF          // LF after payload
    } t_phase;

    localparam logic [L-1:0] LEN_MAX = {L{1'b1}};

    // low 32 bits of an L-bit value, zero-extended when L is narrower
    function automatic logic [NUMBER_W-1:0] low_word(input logic [L-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[NUMBER_W-1:0];
    endfunction

    // parser state
    t_phase        r_phase,     n_phase;
    logic [L-1:0]  r_accum,     n_accum;
    logic          r_minus,     n_minus;
    logic          r_hdr_array, n_hdr_array;
    logic          r_in_array,  n_in_array;
    logic [L-1:0]  r_elem_left, n_elem_left;
    logic [L-1:0]  r_pay_left,  n_pay_left;

    // result register
    logic                r_out_valid;
    t_event              r_event,   n_event;
    logic [NUMBER_W-1:0] r_number,  n_number;
    logic [BYTE_W-1:0]   r_payload, n_payload;
    logic                r_done,    n_done;

    logic              in_fire;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] digit_full;
    logic [3:0]        digit;
    logic              is_digit;
    logic [L+3:0]      acc_next;
    logic              acc_ovf;
    logic [L-1:0]      pay_dec;
    logic [L-1:0]      elem_dec;

    // a new byte is taken whenever the result register is free or draining
    assign i_byte.ready = !r_out_valid || o_res.ready;
    assign in_fire      = i_byte.valid && i_byte.ready;

    assign b          = i_byte.stream_byte;
    assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit_full = b - CH_ZERO;
    assign digit      = digit_full[3:0];

    // accum*10 + digit with four guard bits; any guard bit set means overflow
    assign acc_next = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                    + (L+4)'(digit);
    assign acc_ovf  = |acc_next[L+3:L];

    assign pay_dec  = (r_pay_left  != '0) ? r_pay_left  - L'(1) : r_pay_left;
    assign elem_dec = (r_elem_left != '0) ? r_elem_left - L'(1) : r_elem_left;

    always_comb begin
        logic       fail;
        logic [L-1:0] fail_num;

        fail     = 1'b0;
        fail_num = '0;

        n_phase     = r_phase;
        n_accum     = r_accum;
        n_minus     = r_minus;
        n_hdr_array = r_hdr_array;
        n_in_array  = r_in_array;
        n_elem_left = r_elem_left;
        n_pay_left  = r_pay_left;

        n_event   = EV_CONSUMED;
        n_number  = '0;
        n_payload = '0;
        n_done    = 1'b0;

        unique case (r_phase)
            PH_TYPE: begin
                if (b == CH_DOLLAR) begin
                    n_hdr_array = 1'b0;
                end else if (b == CH_STAR && !r_in_array) begin
                    n_hdr_array = 1'b1;
                end else begin
                    fail = 1'b1;
                end
                n_accum = '0;
                n_minus = 1'b0;
                n_phase = PH_NUM_FIRST;
            end

            PH_NUM_FIRST, PH_NUM_AFTER_MINUS, PH_NUM_DIGITS: begin
                if (is_digit) begin
                    if (acc_ovf) begin
                        fail     = 1'b1;
                        fail_num = LEN_MAX;
                    end else begin
                        n_accum = acc_next[L-1:0];
                        n_phase = PH_NUM_DIGITS;
                    end
                end else if (r_phase == PH_NUM_FIRST && b == CH_MINUS) begin
                    n_minus = 1'b1;
                    n_phase = PH_NUM_AFTER_MINUS;
                end else if (r_phase == PH_NUM_DIGITS && b == CH_CR) begin
                    n_phase = PH_NUM_LF;
                end else begin
                    fail = 1'b1;
                end
            end

            PH_NUM_LF: begin
                if (b != CH_LF) begin
                    fail = 1'b1;
                end else if (r_hdr_array) begin
                    if (r_minus) begin
                        // only "-1" is legal: null array, everything cleared
                        if (r_accum != L'(1)) begin
                            fail = 1'b1;
                        end else begin
                            n_phase     = PH_TYPE;
                            n_accum     = '0;
                            n_minus     = 1'b0;
                            n_hdr_array = 1'b0;
                            n_in_array  = 1'b0;
                            n_elem_left = '0;
                            n_pay_left  = '0;
                            n_event     = EV_NULL_ARRAY;
                            n_done      = 1'b1;
                        end
                    end else begin
                        n_accum  = '0;
                        n_phase  = PH_TYPE;
                        n_event  = EV_ARRAY_START;
                        if (r_accum == '0) begin
                            // empty array completes the message
                            n_in_array  = 1'b0;
                            n_elem_left = '0;
                            n_done      = 1'b1;
                        end else begin
                            n_in_array  = 1'b1;
                            n_elem_left = r_accum;
                            n_number    = low_word(r_accum);
                        end
                    end
                end else if (r_minus) begin
                    fail = 1'b1;
                end else begin
                    n_accum    = '0;
                    n_pay_left = r_accum;
                    n_phase    = (r_accum == '0) ? PH_BODY_CR : PH_BODY;
                    n_event    = EV_BULK_START;
                    n_number   = low_word(r_accum);
                end
            end

            PH_BODY: begin
                n_pay_left = pay_dec;
                if (pay_dec == '0) begin
                    n_phase = PH_BODY_CR;
                end
                n_event   = EV_PAYLOAD;
                n_payload = b;
            end

            PH_BODY_CR: begin
                if (b != CH_CR) begin
                    fail = 1'b1;
                end else begin
                    n_phase = PH_BODY_LF;
                end
            end

            PH_BODY_LF: begin
                if (b != CH_LF) begin
                    fail = 1'b1;
                end else begin
                    n_phase = PH_TYPE;
                    n_event = EV_BULK_END;
                    if (r_in_array) begin
                        n_elem_left = elem_dec;
                        if (elem_dec == '0) begin
                            n_in_array = 1'b0;
                            n_done     = 1'b1;
                        end
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end

            default: begin
                fail = 1'b1;
            end
        endcase

        // any error: back to reset state, wait for a new message
        if (fail) begin
            n_phase     = PH_TYPE;
            n_accum     = '0;
            n_minus     = 1'b0;
            n_hdr_array = 1'b0;
            n_in_array  = 1'b0;
            n_elem_left = '0;
            n_pay_left  = '0;
            n_event     = EV_ERROR;
            n_number    = low_word(fail_num);
            n_payload   = '0;
            n_done      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_accum     <= '0;
            r_minus     <= 1'b0;
            r_hdr_array <= 1'b0;
            r_in_array  <= 1'b0;
            r_elem_left <= '0;
            r_pay_left  <= '0;
            r_out_valid <= 1'b0;
            r_event     <= EV_CONSUMED;
            r_number    <= '0;
            r_payload   <= '0;
            r_done      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase     <= n_phase;
                r_accum     <= n_accum;
                r_minus     <= n_minus;
                r_hdr_array <= n_hdr_array;
                r_in_array  <= n_in_array;
                r_elem_left <= n_elem_left;
                r_pay_left  <= n_pay_left;
                r_out_valid <= 1'b1;
                r_event     <= n_event;
                r_number    <= n_number;
                r_payload   <= n_payload;
                r_done      <= n_done;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_event;
    assign o_res.number       = r_number;
    assign o_res.payload      = r_payload;
    assign o_res.message_done = r_done;

    // an error always leaves the parser at a message boundary
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_event == EV_ERROR |=>
            r_phase == PH_TYPE && !r_in_array && r_elem_left == '0 && r_pay_left == '0)
        else $error("error did not clear parser state");

    // open array always has elements due
    a_array_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_array |-> r_elem_left != '0)
        else $error("inside array with no elements left");

    // body phase always has payload due
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_pay_left != '0)
        else $error("payload phase with zero bytes left");

    // message end only on events that can close a message
    a_done_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |->
            (r_event == EV_ARRAY_START || r_event == EV_NULL_ARRAY ||
             r_event == EV_BULK_END))
        else $error("message_done on wrong event");

    // payload byte is zero outside payload events
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_event != EV_PAYLOAD |-> r_payload == '0)
        else $error("payload set on non-payload event");

endmodule
